FILE: rtl/tcr_pkg.sv
package tcr_pkg;

  localparam int CW   = 16;           // coordinate width
  localparam int DW   = CW + 1;       // edge vector component width
  localparam int AW   = 2 * DW;       // doubled signed area width
  localparam int LW   = 2 * DW - 1;   // squared edge length width
  localparam int MW   = 2 * DW - 1;   // area magnitude width
  localparam int HW   = (LW + 1) / 2; // low split of a length for the first product
  localparam int QW   = 2 * MW + 2;   // divisor 4*D^2 width
  localparam int PW   = 3 * LW;       // numerator product width
  localparam int QB   = 64;           // quotient bits kept
  localparam int RB   = QB / 2;       // root bits
  localparam int SRW  = RB + 2;       // root remainder width

  typedef struct packed {
    logic [CW-1:0] ax;
    logic [CW-1:0] ay;
    logic [CW-1:0] bx;
    logic [CW-1:0] by_coord;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
  } coord_t;

  typedef struct packed {
    logic deg;
    logic ovf;
  } flags_t;

  typedef struct packed {
    flags_t        flags;
    logic [QW-1:0] rem;
    logic [QB-1:0] nq;   // numerator bits out at the top, quotient bits in at the bottom
    logic [QW-1:0] q;
  } dstep_t;

  typedef struct packed {
    flags_t         flags;
    logic [SRW-1:0] rem;
    logic [RB-1:0]  root;
    logic [QB-1:0]  x;
  } sstep_t;

endpackage

FILE: rtl/triangle_circumradius.sv
// Triangle circumradius, one word in and one word out per triangle.
// Input word: vertices a, b, c as signed Q8.8 coordinates (ax ... cy).
// Output word: radius as unsigned Q24.8, truncated, plus two flags.
// Collinear vertices give degenerate = 1 and radius all ones; a radius of
// 2^32 raw units or more gives overflow = 1 and radius all ones.
// Both channels use valid/stall: a word moves on a clock edge with valid
// high and stall low.
// A word passes 105 register stages: 8 front stages (edge vectors, squares,
// products), 64 restoring divide stages at one quotient bit each, 32 square
// root stages at one root bit each and the output register. Throughput is one
// triangle per cycle while the pipeline is not held by out_stall.
// When out_stall holds a valid result, the whole pipeline holds; one more
// input word is then caught in an input skid register, and in_stall
// rises the cycle after. in_stall is a register output.
// Synchronous reset clears all valid bits; no word survives reset.
module triangle_circumradius
  import tcr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [CW-1:0] ax,
  input  logic [CW-1:0] ay,
  input  logic [CW-1:0] bx,
  input  logic [CW-1:0] by_coord,
  input  logic [CW-1:0] cx,
  input  logic [CW-1:0] cy,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [RB-1:0] radius,
  output logic          degenerate,
  output logic          overflow
);

  logic   en;
  logic   skid_vld;
  coord_t skid;
  coord_t in_word;
  coord_t src;
  logic   src_vld;

  dstep_t dd [0:QB];
  logic   dv [0:QB];
  sstep_t ss [0:RB];
  logic   sv [0:RB];

  assign en       = !(out_valid && out_stall);
  assign in_stall = skid_vld;

  assign in_word.ax       = ax;
  assign in_word.ay       = ay;
  assign in_word.bx       = bx;
  assign in_word.by_coord = by_coord;
  assign in_word.cx       = cx;
  assign in_word.cy       = cy;

  assign src     = skid_vld ? skid : in_word;
  assign src_vld = skid_vld || in_valid;

  // catch one word while the pipeline holds, drain it first on release
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_vld <= 1'b0;
    end else if (en) begin
      skid_vld <= 1'b0;
    end else if (in_valid && !skid_vld) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && !skid_vld) begin
      skid <= in_word;
    end
  end

  tcr_front u_front (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (src_vld),
    .din  (src),
    .vout (dv[0]),
    .dout (dd[0])
  );

  for (genvar i = 0; i < QB; i++) begin : g_div
    tcr_div_step u_step (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .vin  (dv[i]),
      .din  (dd[i]),
      .vout (dv[i+1]),
      .dout (dd[i+1])
    );
  end

  assign sv[0]          = dv[QB];
  assign ss[0].flags    = dd[QB].flags;
  assign ss[0].rem      = '0;
  assign ss[0].root     = '0;
  assign ss[0].x        = dd[QB].nq;

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    tcr_sqrt_step u_step (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .vin  (sv[j]),
      .din  (ss[j]),
      .vout (sv[j+1]),
      .dout (ss[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sv[RB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degenerate <= ss[RB].flags.deg;
      overflow   <= ss[RB].flags.ovf && !ss[RB].flags.deg;
      radius     <= (ss[RB].flags.deg || ss[RB].flags.ovf) ? '1 : ss[RB].root;
    end
  end

endmodule

FILE: rtl/tcr_front.sv
module tcr_front
  import tcr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   vin,
  input  coord_t din,
  output logic   vout,
  output dstep_t dout
);

  logic [7:0] v;

  logic signed [DW-1:0] xb, yb, xc, yc, xd, yd;
  logic signed [AW-1:0] sxb, syb, sxc, syc, sxd, syd, ar1, ar2;
  logic [LW-1:0] lba, lca, lbc, lbc4, lbc5;
  logic signed [AW-1:0] area;
  logic [MW-1:0] mag;
  logic deg4, deg5, deg6, deg7;
  logic [LW+HW-1:0] pl, ph;
  logic [2*LW-1:0] lab, msq;
  logic [2*LW-1:0] pa, pb;
  logic [QW-1:0] q6, q7;
  logic [PW-1:0] p7;
  logic signed [AW-1:0] area_neg;

  assign area_neg = -area;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[6:0], vin};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // edge vectors from vertex a, and from vertex b to vertex c
      xb <= {din.bx[CW-1], din.bx} - {din.ax[CW-1], din.ax};
      yb <= {din.by_coord[CW-1], din.by_coord} - {din.ay[CW-1], din.ay};
      xc <= {din.cx[CW-1], din.cx} - {din.ax[CW-1], din.ax};
      yc <= {din.cy[CW-1], din.cy} - {din.ay[CW-1], din.ay};
      xd <= {din.cx[CW-1], din.cx} - {din.bx[CW-1], din.bx};
      yd <= {din.cy[CW-1], din.cy} - {din.by_coord[CW-1], din.by_coord};

      sxb <= xb * xb;
      syb <= yb * yb;
      sxc <= xc * xc;
      syc <= yc * yc;
      sxd <= xd * xd;
      syd <= yd * yd;
      ar1 <= xb * yc;
      ar2 <= yb * xc;

      lba  <= LW'(sxb + syb);
      lca  <= LW'(sxc + syc);
      lbc  <= LW'(sxd + syd);
      area <= ar1 - ar2;

      mag  <= area[AW-1] ? MW'(area_neg) : MW'(area);
      deg4 <= (area == '0);
      lbc4 <= lbc;
      pl   <= (LW+HW)'(lba * lca[HW-1:0]);
      ph   <= (LW+HW)'(lba * lca[LW-1:HW]);

      lab  <= (2*LW)'(pl) + ((2*LW)'(ph) << HW);
      msq  <= mag * mag;
      deg5 <= deg4;
      lbc5 <= lbc4;

      pa   <= lab[LW-1:0] * lbc5;
      pb   <= lab[2*LW-1:LW] * lbc5;
      q6   <= {msq, 2'b00};
      deg6 <= deg5;

      p7   <= PW'(pa) + {pb, {LW{1'b0}}};
      q7   <= q6;
      deg7 <= deg6;

      // quotient of 2^QB or more saturates
      dout.flags.deg <= deg7;
      dout.flags.ovf <= ((QW+QB)'(p7) >= {q7, {QB{1'b0}}});
      dout.rem       <= QW'(p7[PW-1:QB]);
      dout.nq        <= p7[QB-1:0];
      dout.q         <= q7;
    end
  end

  assign vout = v[7];

endmodule

FILE: rtl/tcr_div_step.sv
module tcr_div_step
  import tcr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   vin,
  input  dstep_t din,
  output logic   vout,
  output dstep_t dout
);

  logic [QW:0] r2;
  logic [QW:0] diff;
  logic        ge;

  assign r2   = {din.rem, din.nq[QB-1]};
  assign diff = r2 - {1'b0, din.q};
  assign ge   = (r2 >= {1'b0, din.q});

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.flags <= din.flags;
      dout.rem   <= ge ? diff[QW-1:0] : r2[QW-1:0];
      dout.nq    <= {din.nq[QB-2:0], ge};
      dout.q     <= din.q;
    end
  end

endmodule

FILE: rtl/tcr_sqrt_step.sv
module tcr_sqrt_step
  import tcr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   vin,
  input  sstep_t din,
  output logic   vout,
  output sstep_t dout
);

  logic [SRW+1:0] r4;
  logic [SRW+1:0] t;
  logic [SRW+1:0] diff;
  logic           ge;

  // bring down two bits, try root*4+1
  assign r4   = {din.rem, din.x[QB-1:QB-2]};
  assign t    = {2'b00, din.root, 2'b01};
  assign diff = r4 - t;
  assign ge   = (r4 >= t);

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.flags <= din.flags;
      dout.rem   <= ge ? diff[SRW-1:0] : r4[SRW-1:0];
      dout.root  <= {din.root[RB-2:0], ge};
      dout.x     <= {din.x[QB-3:0], 2'b00};
    end
  end

endmodule
